// ===== hw/rtl/ttd_pkg.sv =====
// shared constants and types for the ttl duplicate filter
package ttd_pkg;

    localparam int CAPACITY = 2048;
    localparam int KEY_BITS = 64;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int ADDR_W = IDX_W + 1;
    localparam int CNT_W = $clog2(CAPACITY + 2);
    localparam int CMP_W = (CNT_W > 12) ? CNT_W : 12;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TTL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX = CFG_IDX_W'(1);

    localparam logic [15:0] TTL_RESET = 16'd300;
    localparam logic [11:0] MAX_RESET = 12'd2000;

    typedef struct packed {
        logic [63:0] message_key;
        logic        key_present;
        logic [31:0] now_seconds;
    } req_word_t;

    typedef struct packed {
        logic        dup_flag;
        logic [11:0] live_count;
    } rsp_word_t;

    typedef struct packed {
        logic [15:0] ttl_seconds;
        logic [11:0] max_entries;
    } cfg_t;

    typedef struct packed {
        logic                live;
        logic [31:0]         stamp;
        logic [KEY_BITS-1:0] key;
    } entry_t;

    typedef struct packed {
        logic        live;
        logic        hit;
        logic        expired;
        logic [31:0] age;
    } eval_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
    } ram_cmd_t;

endpackage

// ===== hw/rtl/ttd_entry_ram.sv =====
// entry table: one write port, one registered read port
module ttd_entry_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/ttd_entry_eval.sv =====
// per-entry match, age and expiry evaluation of a table read
module ttd_entry_eval import ttd_pkg::*; (
    input  entry_t              entry,
    input  logic [KEY_BITS-1:0] key,
    input  logic [31:0]         now,
    input  logic [15:0]         ttl,
    output eval_t               ev
);

    logic [31:0] age;

    assign age        = now - entry.stamp;
    assign ev.live    = entry.live;
    assign ev.hit     = (entry.key == key);
    assign ev.age     = age;
    assign ev.expired = (age >= {16'b0, ttl});

endmodule

// ===== hw/rtl/ttd_ctrl.sv =====
// scan sequencer: clear, match, prune, evict and place over the entry table
module ttd_ctrl import ttd_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_accept,
    input  req_word_t           req_word,
    output logic                idle,
    input  cfg_t                cfg,
    output ram_cmd_t            ram_cmd,
    output entry_t              wr_data,
    input  eval_t               ev,
    output logic [KEY_BITS-1:0] key,
    output logic [31:0]         now,
    output logic                res_valid,
    input  logic                res_take,
    output rsp_word_t           res_word
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_MATCH  = 3'd2;
    localparam logic [2:0] S_PRUNE  = 3'd3;
    localparam logic [2:0] S_EVICT  = 3'd4;
    localparam logic [2:0] S_PLACE  = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic                pend_reg, pend_next;
    logic                dup_reg, dup_next;
    logic                match_found_reg, match_found_next;
    logic                match_fresh_reg, match_fresh_next;
    logic [IDX_W-1:0]    match_idx_reg, match_idx_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic                best_found_reg, best_found_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [31:0]         best_age_reg, best_age_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [31:0]         now_reg, now_next;

    logic                in_scan;
    logic                scan_issue;
    logic                scan_done;
    logic [CMP_W-1:0]    limit;
    logic [CNT_W-1:0]    total_tmp;
    logic                more;
    logic                free_cand_en;
    logic [IDX_W-1:0]    free_cand_idx;

    assign in_scan    = state_reg inside {S_MATCH, S_PRUNE, S_EVICT};
    assign scan_issue = (addr_reg != ADDR_W'(CAPACITY));
    assign scan_done  = !scan_issue && !rd_vld_reg;
    assign limit      = (CMP_W'(cfg.max_entries) < CMP_W'(CAPACITY)) ?
                        CMP_W'(cfg.max_entries) : CMP_W'(CAPACITY);

    always_comb
    begin
        state_next       = state_reg;
        addr_next        = addr_reg;
        rd_vld_next      = 1'b0;
        rd_idx_next      = rd_idx_reg;
        count_next       = count_reg;
        total_next       = total_reg;
        pend_next        = pend_reg;
        dup_next         = dup_reg;
        match_found_next = match_found_reg;
        match_fresh_next = match_fresh_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        best_found_next  = best_found_reg;
        best_idx_next    = best_idx_reg;
        best_age_next    = best_age_reg;
        key_next         = key_reg;
        now_next         = now_reg;
        total_tmp        = total_reg;
        more             = 1'b0;
        free_cand_en     = 1'b0;
        free_cand_idx    = rd_idx_reg;
        ram_cmd          = '0;
        wr_data          = '{live: 1'b0, stamp: now_reg, key: key_reg};

        // sequential read sweep, data arrives in the next cycle
        if (in_scan && scan_issue)
        begin
            ram_cmd.rd_en   = 1'b1;
            ram_cmd.rd_addr = addr_reg[IDX_W-1:0];
            addr_next       = addr_reg + ADDR_W'(1);
            rd_vld_next     = 1'b1;
            rd_idx_next     = addr_reg[IDX_W-1:0];
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_cmd.wr_en   = 1'b1;
                ram_cmd.wr_addr = addr_reg[IDX_W-1:0];
                addr_next       = addr_reg + ADDR_W'(1);
                if (addr_reg == ADDR_W'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_accept)
                begin
                    key_next = req_word.message_key[KEY_BITS-1:0];
                    now_next = req_word.now_seconds;
                    dup_next = 1'b0;
                    if (req_word.key_present)
                    begin
                        match_found_next = 1'b0;
                        free_found_next  = 1'b0;
                        addr_next        = '0;
                        state_next       = S_MATCH;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end

            S_MATCH:
            begin
                if (rd_vld_reg)
                begin
                    if (ev.live && ev.hit && !match_found_reg)
                    begin
                        match_found_next = 1'b1;
                        match_fresh_next = !ev.expired;
                        match_idx_next   = rd_idx_reg;
                    end
                    free_cand_en = !ev.live;
                end
                if (scan_done)
                begin
                    if (match_found_reg && match_fresh_reg)
                    begin
                        dup_next   = 1'b1;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        total_tmp = count_reg + CNT_W'(1);
                        if (match_found_reg)
                        begin
                            // expired match leaves the table before the key is re-recorded
                            ram_cmd.wr_en   = 1'b1;
                            ram_cmd.wr_addr = match_idx_reg;
                            free_cand_en    = 1'b1;
                            free_cand_idx   = match_idx_reg;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CNT_W'(1);
                                total_tmp  = count_reg;
                            end
                        end
                        pend_next  = 1'b1;
                        total_next = total_tmp;
                        if (CMP_W'(total_tmp) > limit)
                        begin
                            addr_next  = '0;
                            state_next = S_PRUNE;
                        end
                        else
                        begin
                            state_next = S_PLACE;
                        end
                    end
                end
            end

            S_PRUNE:
            begin
                if (rd_vld_reg && ev.live && ev.expired)
                begin
                    ram_cmd.wr_en   = 1'b1;
                    ram_cmd.wr_addr = rd_idx_reg;
                    total_next      = total_reg - CNT_W'(1);
                    free_cand_en    = 1'b1;
                end
                if (scan_done)
                begin
                    if (cfg.ttl_seconds == 16'd0)
                    begin
                        // zero ttl: the pending key is itself expired
                        pend_next = 1'b0;
                        total_tmp = total_reg - CNT_W'(1);
                    end
                    total_next = total_tmp;
                    if (CMP_W'(total_tmp) > limit)
                    begin
                        addr_next       = '0;
                        best_found_next = 1'b0;
                        state_next      = S_EVICT;
                    end
                    else
                    begin
                        state_next = S_PLACE;
                    end
                end
            end

            S_EVICT:
            begin
                if (rd_vld_reg && ev.live && (!best_found_reg || ev.age > best_age_reg))
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = rd_idx_reg;
                    best_age_next   = ev.age;
                end
                if (scan_done)
                begin
                    if (best_found_reg)
                    begin
                        ram_cmd.wr_en   = 1'b1;
                        ram_cmd.wr_addr = best_idx_reg;
                        free_cand_en    = 1'b1;
                        free_cand_idx   = best_idx_reg;
                        total_tmp       = total_reg - CNT_W'(1);
                        more            = 1'b1;
                    end
                    else if (pend_reg)
                    begin
                        // the new key wins ties: stored entries are evicted first, so the new key goes last
                        pend_next = 1'b0;
                        total_tmp = total_reg - CNT_W'(1);
                        more      = 1'b1;
                    end
                    total_next = total_tmp;
                    if (more && (CMP_W'(total_tmp) > limit))
                    begin
                        addr_next       = '0;
                        best_found_next = 1'b0;
                    end
                    else
                    begin
                        state_next = S_PLACE;
                    end
                end
            end

            S_PLACE:
            begin
                if (pend_reg)
                begin
                    ram_cmd.wr_en   = 1'b1;
                    ram_cmd.wr_addr = free_idx_reg;
                    wr_data         = '{live: 1'b1, stamp: now_reg, key: key_reg};
                end
                count_next = total_reg;
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // lowest free slot tracking
        if (free_cand_en && (!free_found_reg || free_cand_idx < free_idx_reg))
        begin
            free_found_next = 1'b1;
            free_idx_next   = free_cand_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            addr_reg        <= '0;
            rd_vld_reg      <= 1'b0;
            count_reg       <= '0;
            pend_reg        <= 1'b0;
            dup_reg         <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_found_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            addr_reg        <= addr_next;
            rd_vld_reg      <= rd_vld_next;
            count_reg       <= count_next;
            pend_reg        <= pend_next;
            dup_reg         <= dup_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            best_found_reg  <= best_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg      <= rd_idx_next;
        total_reg       <= total_next;
        match_fresh_reg <= match_fresh_next;
        match_idx_reg   <= match_idx_next;
        free_idx_reg    <= free_idx_next;
        best_idx_reg    <= best_idx_next;
        best_age_reg    <= best_age_next;
        key_reg         <= key_next;
        now_reg         <= now_next;
    end

    assign idle                = (state_reg == S_IDLE);
    assign res_valid           = (state_reg == S_RESULT);
    assign res_word.dup_flag   = dup_reg;
    assign res_word.live_count = 12'(count_reg);
    assign key                 = key_reg;
    assign now                 = now_reg;

endmodule

// ===== hw/rtl/ttl_dedup_filter.sv =====
// top level of the ttl duplicate filter: config registers, output stage, table
//
//  channel   handshake            word
//  req       req_valid/req_stall  req_word  (message_key, key_present, now_seconds)
//  rsp       rsp_valid/rsp_stall  rsp_word  (dup_flag, live_count)
//  cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// empty key: no sweep; the result state hands the word on to the output register
// present key: a match sweep over the table, then a place step unless a duplicate
// over the limit: a prune sweep, then while still over one evict sweep per eviction
// result stage waits until the output register can take the word, then returns to idle for the next accept
// after reset a clearing pass over every entry runs with req_stall high
// rsp word waits in an output register; a new req word is taken while it waits
module ttl_dedup_filter import ttd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_word_t             req_word,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_word_t             rsp_word,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                cfg_reg, cfg_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_word_t           rsp_word_reg, rsp_word_next;

    logic                idle;
    logic                req_accept;
    ram_cmd_t            ram_cmd;
    entry_t              wr_data;
    entry_t              rd_data;
    eval_t               ev;
    logic [KEY_BITS-1:0] key;
    logic [31:0]         now;
    logic                res_valid;
    logic                res_take;
    rsp_word_t           res_word;

    assign req_stall  = !idle;
    assign req_accept = req_valid && idle;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TTL:
                begin
                    cfg_next.ttl_seconds = cfg_data;
                end
                CFG_MAX:
                begin
                    cfg_next.max_entries = cfg_data[11:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    assign res_take = res_valid && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
            rsp_word_next  = res_word;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '{ttl_seconds: TTL_RESET, max_entries: MAX_RESET};
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    ttd_entry_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_cmd.wr_en),
        .wr_addr (ram_cmd.wr_addr),
        .wr_data (wr_data),
        .rd_en   (ram_cmd.rd_en),
        .rd_addr (ram_cmd.rd_addr),
        .rd_data (rd_data)
    );

    ttd_entry_eval u_eval (
        .entry (rd_data),
        .key   (key),
        .now   (now),
        .ttl   (cfg_reg.ttl_seconds),
        .ev    (ev)
    );

    ttd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_accept (req_accept),
        .req_word   (req_word),
        .idle       (idle),
        .cfg        (cfg_reg),
        .ram_cmd    (ram_cmd),
        .wr_data    (wr_data),
        .ev         (ev),
        .key        (key),
        .now        (now),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res_word   (res_word)
    );

endmodule

// ===== dv/ttd_check_pkg.sv =====
// scoreboard for the ttl duplicate filter: table model and result word checks
`timescale 1ns / 100ps

package ttd_check_pkg;

    import ttd_pkg::*;

    class dedup_tracker;

        bit [15:0]         ttl;
        bit [11:0]         max_keys;
        bit [KEY_BITS-1:0] key_tab [CAPACITY];
        bit [31:0]         stamp_tab [CAPACITY];
        bit                live_tab [CAPACITY];
        int unsigned       held;
        rsp_word_t         pending_rsp [$];
        int                errors;

        function new();
            ttl = TTL_RESET;
            max_keys = MAX_RESET;
            held = 0;
            errors = 0;
            foreach (live_tab[i])
            begin
                live_tab[i] = 1'b0;
                key_tab[i] = '0;
                stamp_tab[i] = '0;
            end
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_TTL)
            begin
                ttl = data;
            end
            else if (idx == CFG_MAX)
            begin
                max_keys = data[11:0];
            end
        endfunction

        function rsp_word_t lookup_and_record(req_word_t w);
            rsp_word_t         r;
            bit [KEY_BITS-1:0] key;
            bit [31:0]         age;
            bit [31:0]         best_age;
            int                best;
            int                total;
            int                lim;
            bit                alive;
            bit                found;

            key = w.message_key[KEY_BITS-1:0];
            r.dup_flag = 1'b0;
            r.live_count = 12'(held);
            if (!w.key_present)
            begin
                return r;
            end

            for (int i = 0; i < CAPACITY; i++)
            begin
                if (live_tab[i] && key_tab[i] == key)
                begin
                    age = w.now_seconds - stamp_tab[i];
                    if (age < {16'd0, ttl})
                    begin
                        r.dup_flag = 1'b1;
                        return r;
                    end
                    live_tab[i] = 1'b0;
                    if (held > 0)
                    begin
                        held--;
                    end
                    break;
                end
            end

            alive = 1'b1;
            total = held + 1;
            lim = (max_keys < CAPACITY) ? int'(max_keys) : CAPACITY;

            if (total > lim)
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    age = w.now_seconds - stamp_tab[i];
                    if (live_tab[i] && age >= {16'd0, ttl})
                    begin
                        live_tab[i] = 1'b0;
                        total--;
                    end
                end
                if (ttl == 16'd0)
                begin
                    alive = 1'b0;
                    total--;
                end
                while (total > lim)
                begin
                    found = 1'b0;
                    best = 0;
                    best_age = '0;
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (live_tab[i])
                        begin
                            age = w.now_seconds - stamp_tab[i];
                            if (!found || age > best_age)
                            begin
                                found = 1'b1;
                                best = i;
                                best_age = age;
                            end
                        end
                    end
                    if (found)
                    begin
                        live_tab[best] = 1'b0;
                    end
                    else if (alive)
                    begin
                        alive = 1'b0;
                    end
                    else
                    begin
                        break;
                    end
                    total--;
                end
            end

            if (alive)
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (!live_tab[i])
                    begin
                        live_tab[i] = 1'b1;
                        key_tab[i] = key;
                        stamp_tab[i] = w.now_seconds;
                        break;
                    end
                end
            end
            held = total;
            r.live_count = 12'(held);
            return r;
        endfunction

        function void note_request(req_word_t w);
            pending_rsp.push_back(lookup_and_record(w));
        endfunction

        function void check_response(rsp_word_t got);
            rsp_word_t want;

            if (pending_rsp.size() == 0)
            begin
                $display("%0t: result word with none expected: dup %0b count %0d",
                         $time, got.dup_flag, got.live_count);
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            if (got.dup_flag !== want.dup_flag)
            begin
                $display("%0t: dup_flag expected %0b actual %0b",
                         $time, want.dup_flag, got.dup_flag);
                errors++;
            end
            if (got.live_count !== want.live_count)
            begin
                $display("%0t: live_count expected %0d actual %0d",
                         $time, want.live_count, got.live_count);
                errors++;
            end
        endfunction

    endclass

endpackage

// ===== dv/ttl_dedup_filter_test.sv =====
// testbench for ttl_dedup_filter: directed and random keys checked against a table model
`timescale 1ns / 100ps

module ttl_dedup_filter_test;

    import ttd_pkg::*;
    import ttd_check_pkg::*;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int HOLD_CYCLES = 12000;
    localparam int KEY_POOL = 12;
    localparam int PHASE_ITEMS = 27;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'hF;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    req_word_t             req_word;
    logic                  rsp_valid;
    logic                  rsp_stall;
    rsp_word_t             rsp_word;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dedup_tracker tracker = new();

    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_left = 0;
    int unsigned step_max = 1;
    bit [31:0]   clock_now;
    bit [63:0]   key_pool [KEY_POOL];

    ttl_dedup_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    initial
    begin
        int ticks;

        ticks = 0;
        while (ticks < CYCLE_LIMIT)
        begin
            @(posedge clk);
            ticks++;
        end
        $display("ttl_dedup_filter test failed");
        $finish;
    end

    // result word sink with random stall and long hold-off
    initial
    begin
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                tracker.check_response(rsp_word);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic send_request(input bit [63:0] key, input bit present, input bit [31:0] now);
        req_word_t w;

        w.message_key = key;
        w.key_present = present;
        w.now_seconds = now;
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word <= w;
        do
            @(posedge clk);
        while (req_stall);
        tracker.note_request(w);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (tracker.pending_rsp.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.apply_reg(idx, data);
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] ttl, input logic [CFG_DATA_W-1:0] lim);
        write_reg(CFG_TTL, ttl);
        write_reg(CFG_MAX, lim);
        cfg_valid <= 1'b0;
        step_max = ttl / 4 + 1;
    endtask

    task automatic run_random(input int count);
        int        sent;
        bit [63:0] key;
        bit        present;

        sent = 0;
        while (sent < count)
        begin
            present = ($urandom_range(9) != 0);
            if ($urandom_range(7) == 0)
            begin
                key = {$urandom, $urandom};
            end
            else
            begin
                key = key_pool[$urandom_range(KEY_POOL - 1)];
            end
            case ($urandom_range(19))
                0: clock_now += $urandom;
                1: clock_now -= $urandom_range(3);
                default: clock_now += $urandom_range(step_max);
            endcase
            send_request(key, present, clock_now);
            if (present)
            begin
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req_word <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        foreach (key_pool[i])
        begin
            key_pool[i] = {$urandom, $urandom};
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, wrap, empty key, expiry
        send_request(64'h0, 1'b1, 32'h0);
        send_request('1, 1'b1, 32'hFFFF_FFFF);
        send_request(64'h0, 1'b1, 32'hFFFF_FFFF);
        send_request('1, 1'b0, 32'hFFFF_FFFF);
        send_request('1, 1'b1, 32'h0);
        wait_idle();

        // zero ttl, new key pruned along with the table
        write_reg(CFG_SPARE, 16'hFFFF);
        set_regs(16'd0, 16'd2);
        send_request(64'h0123_4567_89AB_CDEF, 1'b1, 32'd100);
        send_request(64'h0123_4567_89AB_CDEF, 1'b1, 32'd100);
        send_request(64'h0123_4567_89AB_CDEF, 1'b1, 32'd100);
        wait_idle();

        // oldest eviction with equal ages
        set_regs(16'hFFFF, 16'd3);
        send_request(64'hFEDC_BA98_7654_3210, 1'b1, 32'd1000);
        send_request(64'h5555_AAAA_5555_AAAA, 1'b1, 32'd1000);
        send_request(64'hAAAA_5555_AAAA_5555, 1'b1, 32'd1000);
        send_request(64'h8000_0000_0000_0001, 1'b1, 32'd1000);
        send_request(64'hFEDC_BA98_7654_3210, 1'b1, 32'd1000);
        send_request(64'hAAAA_5555_AAAA_5555, 1'b1, 32'd1000);
        wait_idle();

        // limit zero
        set_regs(16'hFFFF, 16'hF000);
        send_request(64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 32'd2000);
        wait_idle();

        // limit above capacity, ttl boundary, time going backwards
        set_regs(16'd5, 16'h0FFF);
        send_request(64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 32'd3000);
        send_request(64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 32'd3004);
        send_request(64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 32'd3005);
        send_request(64'h0F0F_0F0F_0F0F_0F0F, 1'b0, 32'd3005);
        send_request(64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 32'd3000);
        send_request(64'h0F0F_0F0F_0F0F_0F0F, 1'b1, 32'd3000);
        wait_idle();

        clock_now = $urandom;

        // no idling, receiver holds off so the block backs up
        set_regs(16'($urandom_range(40, 5)), 16'($urandom_range(6, 2)));
        hold_left = HOLD_CYCLES;
        run_random(PHASE_ITEMS);
        wait_idle();

        idle_pct = 57;
        stall_pct = 0;
        set_regs(16'($urandom_range(30, 1)), 16'($urandom_range(8, 1)));
        run_random(PHASE_ITEMS);
        wait_idle();

        idle_pct = 0;
        stall_pct = 57;
        set_regs(16'hFFFF, 16'h0800);
        run_random(PHASE_ITEMS);
        wait_idle();

        idle_pct = 12;
        stall_pct = 12;
        set_regs(16'($urandom_range(10)), 16'($urandom_range(4, 1)));
        run_random(PHASE_ITEMS);
        wait_idle();

        repeat (2 * CAPACITY + 64) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_rsp.size() == 0)
        begin
            $display("ttl_dedup_filter test passed");
        end
        else
        begin
            $display("ttl_dedup_filter test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ttd_pkg.sv
hw/rtl/ttd_entry_ram.sv
hw/rtl/ttd_entry_eval.sv
hw/rtl/ttd_ctrl.sv
hw/rtl/ttl_dedup_filter.sv
dv/ttd_check_pkg.sv
dv/ttl_dedup_filter_test.sv
